// ----- hw/rtl/mfd_pkg.sv -----
// Shared types, codes and constants of the multipart form deframer.
package mfd_pkg;

    localparam int MAX_BOUNDARY_DEF = 56;
    localparam int WORD_W           = 64;
    localparam int BYTE_W           = 8;
    localparam int MI_W             = 6;
    localparam int LEN_W            = 6;
    localparam int CFG_IDX_W        = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_WORD0 = 3'd1;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd2;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_HYPHEN  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;

    typedef enum logic [2:0] {
        KIND_NAME,
        KIND_VALUE,
        KIND_HDR_END,
        KIND_HDRS_DONE,
        KIND_DATA,
        KIND_PART_END,
        KIND_BODY_END,
        KIND_ERROR
    } t_kind;

    typedef enum logic [3:0] {
        PH_OPEN,
        PH_FIELD,
        PH_HDRS_ALMOST,
        PH_VALUE_START,
        PH_VALUE,
        PH_VALUE_ALMOST,
        PH_DATA,
        PH_DATA_CR,
        PH_DELIM,
        PH_AFTER_DELIM,
        PH_FINAL_HYPHEN,
        PH_NEXT_LF,
        PH_END,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_LF,
        SQ_DELIM,
        SQ_TAIL
    } t_seq;

    typedef enum logic [1:0] {
        MI_HOLD,
        MI_CLEAR,
        MI_INC
    } t_mi_op;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_IN,
        SRC_CR,
        SRC_LF,
        SRC_DELIM,
        SRC_TAIL
    } t_src;

    typedef struct packed {
        logic out_free;
        logic ch_cr;
        logic ch_lf;
        logic ch_hyphen;
        logic ch_colon;
        logic ch_space;
        logic ch_letter;
        logic mi_eq_len;
        logic mi_eq_len1;
        logic mi_gt_len1;
        logic mi_lt_len;
        logic mi_last;
        logic ch_eq_delim;
        logic rel_empty;
        logic rel_last;
        logic tail_cr;
    } t_dp_status;

    typedef struct packed {
        logic   rel_active;
        t_mi_op mi_op;
        logic   rel_load;
        logic   rel_step;
        logic   out_load;
        t_kind  out_kind;
        t_src   out_src;
        logic   out_last;
    } t_dp_cmd;

endpackage

// ----- hw/rtl/mfd_dpath.sv -----
// Datapath of the deframer: delimiter registers, match index, release counter, output word.
module mfd_dpath
    import mfd_pkg::*;
#(
    parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_wdata,
    input  logic [BYTE_W-1:0]    i_in_byte,
    input  logic                 i_in_first,
    input  logic                 i_out_ready,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    output t_kind                o_out_kind,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_out_last
);

    localparam int NWORDS = (MAX_BOUNDARY + 7) / 8;
    localparam int FLAT_W = NWORDS * WORD_W;
    localparam int BIDX_W = $clog2(FLAT_W);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BOUNDARY);

    logic [FLAT_W-1:0] r_delim;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [MI_W-1:0]   r_mi;
    logic [MI_W-1:0]   n_mi;
    logic [MI_W-1:0]   eff_mi;
    logic [MI_W-1:0]   r_rel_cnt;
    logic [MI_W-1:0]   r_rel_idx;
    logic [BYTE_W-1:0] r_tail;
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic [BYTE_W-1:0] n_out_byte;
    logic [MI_W-1:0]   rd_idx;
    logic [MI_W+2:0]   bit_idx;
    logic [BYTE_W-1:0] delim_byte;
    logic [MI_W:0]     len1;
    logic [BYTE_W-1:0] lc;

    // The length register keeps the effective value: zero reads as one,
    // anything past the storage reads as the largest delimiter.
    always_comb begin
        if (i_cfg_wdata[LEN_W-1:0] == '0) begin
            n_len = LEN_W'(1);
        end else if (i_cfg_wdata[LEN_W-1:0] > LEN_MAX) begin
            n_len = LEN_MAX;
        end else begin
            n_len = i_cfg_wdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_RESET;
            r_delim <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BOUNDARY_LEN) begin
                r_len <= n_len;
            end
            for (int w = 0; w < NWORDS; w++) begin
                if (i_cfg_index == CFG_IDX_W'(w + 1)) begin
                    r_delim[w*WORD_W +: WORD_W] <= i_cfg_wdata;
                end
            end
        end
    end

    assign eff_mi     = i_in_first ? '0 : r_mi;
    assign rd_idx     = i_cmd.rel_active ? r_rel_idx : eff_mi;
    assign bit_idx    = {rd_idx, 3'b000};
    assign delim_byte = r_delim[bit_idx[BIDX_W-1:0] +: BYTE_W];
    assign len1       = {1'b0, r_len} + (MI_W+1)'(1);
    assign lc         = i_in_byte | CASE_BIT;

    always_comb begin
        o_status.out_free    = !r_out_valid || i_out_ready;
        o_status.ch_cr       = (i_in_byte == CH_CR);
        o_status.ch_lf       = (i_in_byte == CH_LF);
        o_status.ch_hyphen   = (i_in_byte == CH_HYPHEN);
        o_status.ch_colon    = (i_in_byte == CH_COLON);
        o_status.ch_space    = (i_in_byte == CH_SPACE);
        o_status.ch_letter   = lc inside {[CH_LOWER_A:CH_LOWER_Z]};
        o_status.mi_eq_len   = (eff_mi == r_len);
        o_status.mi_eq_len1  = ({1'b0, eff_mi} == len1);
        o_status.mi_gt_len1  = ({1'b0, eff_mi} > len1);
        o_status.mi_lt_len   = (eff_mi < r_len);
        o_status.mi_last     = (({1'b0, eff_mi} + (MI_W+1)'(1)) >= {1'b0, r_len});
        o_status.ch_eq_delim = (i_in_byte == delim_byte);
        o_status.rel_empty   = (r_rel_cnt == '0);
        o_status.rel_last    = (({1'b0, r_rel_idx} + (MI_W+1)'(1)) == {1'b0, r_rel_cnt});
        o_status.tail_cr     = (r_tail == CH_CR);
    end

    always_comb begin
        case (i_cmd.mi_op)
            MI_CLEAR: n_mi = '0;
            MI_INC:   n_mi = eff_mi + MI_W'(1);
            default:  n_mi = r_mi;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mi <= '0;
        end else begin
            r_mi <= n_mi;
        end
    end

    // Held bytes of a broken delimiter match: only a count survives.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rel_load) begin
            r_rel_cnt <= o_status.mi_lt_len ? eff_mi : r_len;
            r_rel_idx <= '0;
            r_tail    <= i_in_byte;
        end else if (i_cmd.rel_step) begin
            r_rel_idx <= r_rel_idx + MI_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.out_src)
            SRC_IN:    n_out_byte = i_in_byte;
            SRC_CR:    n_out_byte = CH_CR;
            SRC_LF:    n_out_byte = CH_LF;
            SRC_DELIM: n_out_byte = delim_byte;
            SRC_TAIL:  n_out_byte = r_tail;
            default:   n_out_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_byte <= n_out_byte;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// ----- hw/rtl/mfd_ctrl.sv -----
// Controller of the deframer: parse phase, release sequencer and datapath commands.
module mfd_ctrl
    import mfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_first,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_phase r_phase;
    t_phase n_phase;
    t_seq   r_seq;
    t_seq   n_seq;
    logic   r_tail_err;
    logic   n_tail_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPEN;
            r_seq      <= SQ_IDLE;
            r_tail_err <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_seq      <= n_seq;
            r_tail_err <= n_tail_err;
        end
    end

    always_comb begin
        t_phase p;
        logic   fail;
        logic   accept;

        n_phase    = r_phase;
        n_seq      = r_seq;
        n_tail_err = r_tail_err;
        fail       = 1'b0;

        o_cmd.rel_active = (r_seq != SQ_IDLE);
        o_cmd.mi_op      = MI_HOLD;
        o_cmd.rel_load   = 1'b0;
        o_cmd.rel_step   = 1'b0;
        o_cmd.out_load   = 1'b0;
        o_cmd.out_kind   = KIND_DATA;
        o_cmd.out_src    = SRC_ZERO;
        o_cmd.out_last   = 1'b0;

        o_in_ready = (r_seq == SQ_IDLE) && i_status.out_free;
        accept     = o_in_ready && i_in_valid;
        p          = i_first ? PH_OPEN : r_phase;

        case (r_seq)
            SQ_IDLE: begin
                if (accept) begin
                    case (p)
                        PH_OPEN: begin
                            if (i_status.mi_eq_len) begin
                                if (i_status.ch_cr) o_cmd.mi_op = MI_INC;
                                else fail = 1'b1;
                            end else if (i_status.mi_eq_len1) begin
                                if (i_status.ch_lf) begin
                                    o_cmd.mi_op = MI_CLEAR;
                                    n_phase     = PH_FIELD;
                                end else begin
                                    fail = 1'b1;
                                end
                            end else if (i_status.mi_gt_len1 || !i_status.ch_eq_delim) begin
                                fail = 1'b1;
                            end else begin
                                o_cmd.mi_op = MI_INC;
                                n_phase     = PH_OPEN;
                            end
                        end
                        PH_FIELD: begin
                            if (i_status.ch_cr) begin
                                n_phase = PH_HDRS_ALMOST;
                            end else if (i_status.ch_colon) begin
                                n_phase = PH_VALUE_START;
                            end else if (i_status.ch_hyphen || i_status.ch_letter) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = KIND_NAME;
                                o_cmd.out_src  = SRC_IN;
                                o_cmd.out_last = 1'b1;
                            end else begin
                                fail = 1'b1;
                            end
                        end
                        PH_HDRS_ALMOST, PH_VALUE_ALMOST: begin
                            if (i_status.ch_lf) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = 1'b1;
                                if (p == PH_HDRS_ALMOST) begin
                                    o_cmd.out_kind = KIND_HDRS_DONE;
                                    n_phase        = PH_DATA;
                                end else begin
                                    o_cmd.out_kind = KIND_HDR_END;
                                    n_phase        = PH_FIELD;
                                end
                            end else begin
                                fail = 1'b1;
                            end
                        end
                        PH_VALUE_START, PH_VALUE: begin
                            if (p == PH_VALUE_START && i_status.ch_space) begin
                                n_phase = PH_VALUE_START;
                            end else if (i_status.ch_cr) begin
                                n_phase = PH_VALUE_ALMOST;
                            end else begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = KIND_VALUE;
                                o_cmd.out_src  = SRC_IN;
                                o_cmd.out_last = 1'b1;
                                n_phase        = PH_VALUE;
                            end
                        end
                        PH_DATA: begin
                            if (i_status.ch_cr) begin
                                n_phase = PH_DATA_CR;
                            end else begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_src  = SRC_IN;
                                o_cmd.out_last = 1'b1;
                            end
                        end
                        PH_DATA_CR: begin
                            if (i_status.ch_lf) begin
                                o_cmd.mi_op = MI_CLEAR;
                                n_phase     = PH_DELIM;
                            end else begin
                                // The lone CR goes out first; the byte follows unless it is a CR.
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_src  = SRC_CR;
                                o_cmd.out_last = i_status.ch_cr;
                                o_cmd.rel_load = 1'b1;
                                n_tail_err     = 1'b0;
                                if (i_status.ch_cr) begin
                                    n_phase = PH_DATA_CR;
                                end else begin
                                    n_phase = PH_DATA;
                                    n_seq   = SQ_TAIL;
                                end
                            end
                        end
                        PH_DELIM: begin
                            if (i_status.mi_lt_len && i_status.ch_eq_delim) begin
                                if (i_status.mi_last) begin
                                    o_cmd.mi_op = MI_CLEAR;
                                    n_phase     = PH_AFTER_DELIM;
                                end else begin
                                    o_cmd.mi_op = MI_INC;
                                end
                            end else begin
                                // Mismatch: release CR, LF, matched delimiter bytes, non-CR byte.
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_src  = SRC_CR;
                                o_cmd.rel_load = 1'b1;
                                o_cmd.mi_op    = MI_CLEAR;
                                n_tail_err     = 1'b0;
                                n_seq          = SQ_LF;
                                n_phase        = i_status.ch_cr ? PH_DATA_CR : PH_DATA;
                            end
                        end
                        PH_AFTER_DELIM: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_kind = KIND_PART_END;
                            o_cmd.out_last = i_status.ch_hyphen || i_status.ch_cr;
                            if (i_status.ch_hyphen) begin
                                n_phase = PH_FINAL_HYPHEN;
                            end else if (i_status.ch_cr) begin
                                n_phase = PH_NEXT_LF;
                            end else begin
                                o_cmd.mi_op = MI_CLEAR;
                                n_phase     = PH_ERROR;
                                n_tail_err  = 1'b1;
                                n_seq       = SQ_TAIL;
                            end
                        end
                        PH_FINAL_HYPHEN: begin
                            if (i_status.ch_hyphen) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = KIND_BODY_END;
                                o_cmd.out_last = 1'b1;
                                n_phase        = PH_END;
                            end else begin
                                fail = 1'b1;
                            end
                        end
                        PH_NEXT_LF: begin
                            if (i_status.ch_lf) n_phase = PH_FIELD;
                            else fail = 1'b1;
                        end
                        default: begin
                            // Body end or error: silent until the next body starts.
                            n_phase = p;
                        end
                    endcase

                    if (fail) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = KIND_ERROR;
                        o_cmd.out_src  = SRC_ZERO;
                        o_cmd.out_last = 1'b1;
                        o_cmd.mi_op    = MI_CLEAR;
                        n_phase        = PH_ERROR;
                    end
                end
            end
            SQ_LF: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = SRC_LF;
                    o_cmd.out_last = i_status.rel_empty && i_status.tail_cr;
                    if (!i_status.rel_empty) n_seq = SQ_DELIM;
                    else if (i_status.tail_cr) n_seq = SQ_IDLE;
                    else n_seq = SQ_TAIL;
                end
            end
            SQ_DELIM: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = SRC_DELIM;
                    o_cmd.rel_step = 1'b1;
                    o_cmd.out_last = i_status.rel_last && i_status.tail_cr;
                    if (i_status.rel_last) begin
                        n_seq = i_status.tail_cr ? SQ_IDLE : SQ_TAIL;
                    end
                end
            end
            SQ_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    if (r_tail_err) begin
                        o_cmd.out_kind = KIND_ERROR;
                        o_cmd.out_src  = SRC_ZERO;
                    end else begin
                        o_cmd.out_kind = KIND_DATA;
                        o_cmd.out_src  = SRC_TAIL;
                    end
                    n_seq = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/multipart_form_deframer.sv -----
// Top level of the multipart form deframer: stream ports, controller and datapath.
// A body byte's first result word reaches the master side in the cycle after the byte is taken.
// Throughput: one body byte per cycle while the output drains and no held bytes are released,
// with results held in one output register; a byte yielding several results (a broken match,
// a lone data CR, a bad byte after a part end) keeps the input closed until its last is loaded.
// Reset: synchronous, active low; parser restarts at the opening delimiter, boundary_len=2,
// boundary words clear, and the output register is emptied.
module multipart_form_deframer
    import mfd_pkg::*;
#(
    parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port: boundary_len at index 0, boundary words at 1 to 7.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_wdata,
    // Body byte stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] body_byte
    input  logic                 s_axis_tuser,  // [0] first_of_body
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [7:0] result_byte
    output logic [2:0]           m_axis_tuser,  // [2:0] result_kind
    output logic                 m_axis_tlast   // last result word caused by one body byte
);

    t_dp_status status;
    t_dp_cmd    cmd;
    t_kind      out_kind;

    // The controller owns the parse phase and the sequencer that plays out the held
    // CR, LF and delimiter bytes when a closing delimiter match breaks. The datapath
    // keeps only the match index, so the delimiter bytes are rebuilt from the boundary words.
    mfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_first    (s_axis_tuser),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // The datapath holds the boundary registers, the match and release counters and
    // the output register, which lets a new body byte enter in the cycle its waiting word is taken.
    mfd_dpath #(
        .MAX_BOUNDARY (MAX_BOUNDARY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_byte   (s_axis_tdata),
        .i_in_first  (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (out_kind),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;

    // A new result word is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result word overwritten before it was taken");

    // The input side is open only when the output register can take a word.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> status.out_free)
        else $error("input accepted with no room for its result");

    // A word that does not end its run keeps the input side closed next cycle.
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && !cmd.out_last) |=> !s_axis_tready)
        else $error("input accepted in the middle of a result run");

    // Each step of a delimiter release produces a data word.
    a_release_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rel_step |-> (cmd.out_load && cmd.out_kind == KIND_DATA))
        else $error("release step without a data word");

endmodule
